// ===== rtl/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// psl_pkg: shared types and codes for the positional list store
// Request/response payload structs, operation and status codes, and the
// slot row control struct passed from the decoder to the storage row.
// ----------------------------------------------------------------------------
`default_nettype none

package psl_pkg;

	// Operation codes carried in the request mode field
	localparam logic [2:0] MODE_INSERT   = 3'd0;
	localparam logic [2:0] MODE_REMOVE   = 3'd1;
	localparam logic [2:0] MODE_RETRIEVE = 3'd2;
	localparam logic [2:0] MODE_REPLACE  = 3'd3;
	localparam logic [2:0] MODE_CLEAR    = 3'd4;

	// Response status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Request payload
	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  position;
		logic [31:0] entry_in;
	} req_t;

	// Response payload
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] entry_out;
		logic [4:0]  entry_count;
	} rsp_t;

	// What the slot row does on an accepted request
	typedef enum logic [1:0] {
		SLOT_HOLD    = 2'd0,
		SLOT_INSERT  = 2'd1,
		SLOT_REMOVE  = 2'd2,
		SLOT_REPLACE = 2'd3
	} slot_op_t;

	// Decoder controls toward the slot row and the response register
	typedef struct packed {
		slot_op_t    op;
		logic [1:0]  status;
		logic        read_out;
	} ctl_t;

endpackage

`default_nettype wire

// ===== rtl/psl_decode.sv =====
// ----------------------------------------------------------------------------
// psl_decode: operation decode and range checks
// Checks the position against the current entry count, picks the slot row
// action, the response status and the next entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_decode #(
	parameter int CAPACITY = 16
) (
	input  wire logic [2:0]                        mode,
	input  wire logic [7:0]                        position,
	input  wire logic [$clog2(CAPACITY+1)-1:0]     held,
	output psl_pkg::ctl_t                          ctl,
	output logic [$clog2(CAPACITY+1)-1:0]          held_next
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 8) ? CW : 8;

	logic [PW-1:0] pos_w;
	logic [PW-1:0] held_w;
	logic [PW-1:0] cap_w;
	logic          ins_range;
	logic          acc_range;

	assign pos_w  = PW'(position);
	assign held_w = PW'(held);
	assign cap_w  = PW'(CAPACITY);

	// insert may address one past the last entry; others must hit an entry
	assign ins_range = pos_w > held_w;
	assign acc_range = pos_w >= held_w;

	// per-operation decode
	always_comb begin
		ctl.op       = psl_pkg::SLOT_HOLD;
		ctl.status   = psl_pkg::ST_OK;
		ctl.read_out = 1'b0;
		held_next    = held;
		case (mode)
			psl_pkg::MODE_INSERT: begin
				if (ins_range) begin
					ctl.status = psl_pkg::ST_RANGE;
				end else if (held_w == cap_w) begin
					ctl.status = psl_pkg::ST_FULL;
				end else begin
					ctl.op    = psl_pkg::SLOT_INSERT;
					held_next = CW'(held + 1'b1);
				end
			end
			psl_pkg::MODE_REMOVE: begin
				if (acc_range) begin
					ctl.status = psl_pkg::ST_RANGE;
				end else begin
					ctl.op       = psl_pkg::SLOT_REMOVE;
					ctl.read_out = 1'b1;
					held_next    = CW'(held - 1'b1);
				end
			end
			psl_pkg::MODE_RETRIEVE: begin
				if (acc_range) begin
					ctl.status = psl_pkg::ST_RANGE;
				end else begin
					ctl.read_out = 1'b1;
				end
			end
			psl_pkg::MODE_REPLACE: begin
				if (acc_range) begin
					ctl.status = psl_pkg::ST_RANGE;
				end else begin
					ctl.op = psl_pkg::SLOT_REPLACE;
				end
			end
			psl_pkg::MODE_CLEAR: begin
				held_next = '0;
			end
			default: begin
				// unused codes leave everything as is
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/psl_slots.sv =====
// ----------------------------------------------------------------------------
// psl_slots: row of entry slots with parallel shift
// Each slot loads the new value, takes its lower or upper neighbor, or holds,
// so an insert or remove at any position updates all slots in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module psl_slots #(
	parameter int CAPACITY    = 16,
	parameter int ENTRY_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire psl_pkg::slot_op_t             op,
	input  wire logic [$clog2(CAPACITY)-1:0]   pos_idx,
	input  wire logic [ENTRY_WIDTH-1:0]        value,
	output logic [ENTRY_WIDTH-1:0]             rd
);

	localparam int IW = $clog2(CAPACITY);

	logic [ENTRY_WIDTH-1:0] slots_q [CAPACITY];
	logic [ENTRY_WIDTH-1:0] lo_nb   [CAPACITY];
	logic [ENTRY_WIDTH-1:0] hi_nb   [CAPACITY];

	// read port at the addressed position, before this cycle's update
	assign rd = slots_q[pos_idx];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		// neighbor taps; the ends see themselves
		if (i == 0) begin : g_lo_end
			assign lo_nb[i] = slots_q[i];
		end else begin : g_lo
			assign lo_nb[i] = slots_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_hi_end
			assign hi_nb[i] = slots_q[i];
		end else begin : g_hi
			assign hi_nb[i] = slots_q[i+1];
		end

		// slot update: load, shift up, shift down or hold
		always_ff @(posedge clk) begin
			if (en) begin
				case (op)
					psl_pkg::SLOT_INSERT: begin
						if (IW'(i) == pos_idx) begin
							slots_q[i] <= value;
						end else if (IW'(i) > pos_idx) begin
							slots_q[i] <= lo_nb[i];
						end
					end
					psl_pkg::SLOT_REMOVE: begin
						if (IW'(i) >= pos_idx) begin
							slots_q[i] <= hi_nb[i];
						end
					end
					psl_pkg::SLOT_REPLACE: begin
						if (IW'(i) == pos_idx) begin
							slots_q[i] <= value;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store: bounded list addressed by position
// Insert, remove, retrieve, replace and clear on up to CAPACITY entries.
// ----------------------------------------------------------------------------
// One request is taken per clock while req_stall is low. After acceptance
// the request sits in the request register while decode, range check and
// the slot row update settle, and all of it lands in the response register
// when the request register advances. Every slot shifts, loads or holds
// in parallel, so an insert or remove at any position costs no more than
// any other request and back-to-back requests run at full rate unless
// stalled. A full response register that is stalled holds the request
// register, which in turn raises req_stall. Slot contents are not cleared
// at reset; only entries below the current count are ever returned.
`default_nettype none

module positional_list_store #(
	parameter int CAPACITY    = 16,
	parameter int ENTRY_WIDTH = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire psl_pkg::req_t  req_data,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output psl_pkg::rsp_t       rsp_data
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = (CW > 8) ? CW : 8;

	psl_pkg::req_t          req_s1;
	logic                   req_valid_s1;
	psl_pkg::rsp_t          rsp_s2;
	logic                   rsp_valid_s2;
	logic [CW-1:0]          held_q;
	logic [CW-1:0]          held_next;
	psl_pkg::ctl_t          ctl;
	logic                   advance;
	logic                   take;
	logic [PW-1:0]          pos_w;
	logic [IW-1:0]          pos_idx;
	logic [ENTRY_WIDTH-1:0] value;
	logic [ENTRY_WIDTH-1:0] rd;

	// request stage moves on when the response register is free or draining
	assign advance   = req_valid_s1 && (!rsp_valid_s2 || !rsp_stall);
	assign req_stall = req_valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	assign pos_w   = PW'(req_s1.position);
	assign pos_idx = pos_w[IW-1:0];
	assign value   = ENTRY_WIDTH'(req_s1.entry_in);

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (take) begin
			req_valid_s1 <= 1'b1;
		end else if (advance) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req_data;
		end
	end

	psl_decode #(
		.CAPACITY (CAPACITY)
	) u_decode (
		.mode      (req_s1.mode),
		.position  (req_s1.position),
		.held      (held_q),
		.ctl       (ctl),
		.held_next (held_next)
	);

	psl_slots #(
		.CAPACITY    (CAPACITY),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_slots (
		.clk     (clk),
		.en      (advance),
		.op      (ctl.op),
		.pos_idx (pos_idx),
		.value   (value),
		.rd      (rd)
	);

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (advance) begin
			held_q <= held_next;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2.status      <= ctl.status;
			rsp_s2.entry_out   <= ctl.read_out ? 32'(rd) : 32'd0;
			rsp_s2.entry_count <= 5'(held_next);
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp_data  = rsp_s2;

	// count never exceeds the slot row
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// a successful insert grows the count by exactly one
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl.op == psl_pkg::SLOT_INSERT |=> held_q == CW'($past(held_q) + 1'b1))
		else $error("insert did not grow count");

	// a full status is only reported at capacity
	a_full_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_s2 && rsp_s2.status == psl_pkg::ST_FULL |->
		rsp_s2.entry_count == 5'(CAPACITY))
		else $error("full status below capacity");

	// stalling only happens with a request held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> req_valid_s1 && rsp_valid_s2)
		else $error("stall without held request");

endmodule

`default_nettype wire
